@@ src/clcd_pkg.sv @@
// Shared types, constants and the power-up nibble table for the 4-bit LCD sequencer.
`default_nettype none

package clcd_pkg;

    // Request kinds
    typedef enum logic [1:0] {
        ACT_CMD    = 2'd0,
        ACT_DATA   = 2'd1,
        ACT_CURSOR = 2'd2,
        ACT_POWER  = 2'd3
    } t_action;

    // Sequencer states of the back end
    typedef enum logic [0:0] {
        ST_HEAD   = 1'b0,
        ST_NIBBLE = 1'b1
    } t_back_state;

    // Classified request as it travels through the queue
    typedef struct packed {
        logic       pwr;       // power-up sequence
        logic       rs;        // RS level for a byte request
        logic [7:0] byte_val;  // byte for a byte request
    } t_op;

    // One nibble of the power-up run
    typedef struct packed {
        logic [3:0] nibble;
        logic [2:0] extra;     // ms added to the settle hold
        logic       keep_rs;   // RS stays at its kept level
    } t_pwr_nib;

    // Cursor address composition
    localparam logic [7:0] CURSOR_CMD = 8'h80;
    localparam logic [7:0] ROW1_BASE  = 8'h40;
    localparam logic [4:0] MAX_COL    = 5'd15;

    // Hold times in ms
    localparam logic [5:0] HOLD_WAIT   = 6'd50;
    localparam logic [5:0] HOLD_PULSE  = 6'd1;
    localparam logic [5:0] HOLD_SETTLE = 6'd2;

    // Strobe phases of one nibble
    localparam logic [1:0] PH_SETUP  = 2'd0;
    localparam logic [1:0] PH_HIGH   = 2'd1;
    localparam logic [1:0] PH_SETTLE = 2'd2;

    // Final nibble index of each run kind
    localparam logic [3:0] BYTE_LAST_NIB = 4'd1;
    localparam logic [3:0] PWR_LAST_NIB  = 4'd11;

    // Power-up run after the initial wait: 3, 3, 3, 2, then 0x28, 0x0C, 0x01, 0x06
    function automatic t_pwr_nib pwr_nibble(input logic [3:0] idx);
        t_pwr_nib ent;
        ent = '{nibble: 4'h0, extra: 3'd0, keep_rs: 1'b0};
        case (idx)
            4'd0:  ent = '{nibble: 4'h3, extra: 3'd5, keep_rs: 1'b1};
            4'd1:  ent = '{nibble: 4'h3, extra: 3'd1, keep_rs: 1'b1};
            4'd2:  ent = '{nibble: 4'h3, extra: 3'd0, keep_rs: 1'b1};
            4'd3:  ent = '{nibble: 4'h2, extra: 3'd0, keep_rs: 1'b1};
            4'd4:  ent = '{nibble: 4'h2, extra: 3'd0, keep_rs: 1'b0};
            4'd5:  ent = '{nibble: 4'h8, extra: 3'd0, keep_rs: 1'b0};
            4'd6:  ent = '{nibble: 4'h0, extra: 3'd0, keep_rs: 1'b0};
            4'd7:  ent = '{nibble: 4'hC, extra: 3'd0, keep_rs: 1'b0};
            4'd8:  ent = '{nibble: 4'h0, extra: 3'd0, keep_rs: 1'b0};
            4'd9:  ent = '{nibble: 4'h1, extra: 3'd5, keep_rs: 1'b0};
            4'd10: ent = '{nibble: 4'h0, extra: 3'd0, keep_rs: 1'b0};
            4'd11: ent = '{nibble: 4'h6, extra: 3'd0, keep_rs: 1'b0};
            default: ent = '{nibble: 4'h0, extra: 3'd0, keep_rs: 1'b0};
        endcase
        return ent;
    endfunction

endpackage

`default_nettype wire

@@ src/clcd_req_if.sv @@
// Request channel: valid/ready with the request fields.
`default_nettype none

interface clcd_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] value;
    logic [1:0] row;
    logic [4:0] col;

    modport source (output valid, output action, output value, output row, output col,
                    input ready);
    modport sink   (input valid, input action, input value, input row, input col,
                    output ready);
endinterface

`default_nettype wire

@@ src/clcd_pin_if.sv @@
// Pin-state channel: valid/ready with one timed pin state per beat.
`default_nettype none

interface clcd_pin_if;
    logic       valid;
    logic       ready;
    logic       rs_level;
    logic       enable_level;
    logic [3:0] nibble;
    logic [5:0] hold_ms;
    logic       last;

    modport source (output valid, output rs_level, output enable_level, output nibble,
                    output hold_ms, output last, input ready);
    modport sink   (input valid, input rs_level, input enable_level, input nibble,
                    input hold_ms, input last, output ready);
endinterface

`default_nettype wire

@@ src/char_lcd_4bit_sequencer_unit.sv @@
// Top level: 4-bit character LCD sequencer with front end, op queue and back end.
// A request passes the front-end register, the op queue and the back-end output register.
// The back-end sequencer issues one pin state per cycle while the pin channel is not
// stalled: two nibbles per byte request, a wait and twelve nibbles per power-up.
// The front end takes a new request every cycle while the op queue has room.
// Reset (synchronous, active low) empties the queue and clears kept RS and data pins.
`default_nettype none

module char_lcd_4bit_sequencer_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    clcd_req_if.sink   i_req,
    clcd_pin_if.source o_pin
);

    clcd_pkg::t_op w_front_op;
    logic          w_front_valid;
    logic          w_queue_ready;
    clcd_pkg::t_op w_head_op;
    logic          w_head_valid;
    logic          w_head_pop;

    clcd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .o_op       (w_front_op),
        .o_op_valid (w_front_valid),
        .i_op_ready (w_queue_ready)
    );

    clcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_front_valid),
        .o_push_ready (w_queue_ready),
        .i_push_op    (w_front_op),
        .o_pop_valid  (w_head_valid),
        .i_pop        (w_head_pop),
        .o_pop_op     (w_head_op)
    );

    clcd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (w_head_valid),
        .i_op       (w_head_op),
        .o_op_pop   (w_head_pop),
        .o_pin      (o_pin)
    );

endmodule

`default_nettype wire

@@ src/clcd_front.sv @@
// Front end: takes request beats, classifies them into byte or power-up ops.
`default_nettype none

module clcd_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    clcd_req_if.sink          i_req,
    output clcd_pkg::t_op     o_op,
    output logic              o_op_valid,
    input  wire logic         i_op_ready
);

    logic          r_valid;
    clcd_pkg::t_op r_op;
    clcd_pkg::t_op n_op;
    logic          w_accept;
    logic          w_row1;
    logic [3:0]    w_col;
    logic [7:0]    w_addr_cmd;

    assign i_req.ready = !r_valid || i_op_ready;
    assign w_accept    = i_req.valid && i_req.ready;

    // Cursor clamp and address command
    always_comb begin
        w_row1     = (i_req.row != 2'd0);
        w_col      = (i_req.col > clcd_pkg::MAX_COL) ? clcd_pkg::MAX_COL[3:0]
                                                     : i_req.col[3:0];
        w_addr_cmd = clcd_pkg::CURSOR_CMD | (w_row1 ? clcd_pkg::ROW1_BASE : 8'h00)
                   | {4'h0, w_col};
    end

    // Classify
    always_comb begin
        n_op = '{pwr: 1'b0, rs: 1'b0, byte_val: i_req.value};
        case (clcd_pkg::t_action'(i_req.action))
            clcd_pkg::ACT_CMD:    n_op = '{pwr: 1'b0, rs: 1'b0, byte_val: i_req.value};
            clcd_pkg::ACT_DATA:   n_op = '{pwr: 1'b0, rs: 1'b1, byte_val: i_req.value};
            clcd_pkg::ACT_CURSOR: n_op = '{pwr: 1'b0, rs: 1'b0, byte_val: w_addr_cmd};
            clcd_pkg::ACT_POWER:  n_op = '{pwr: 1'b1, rs: 1'b0, byte_val: 8'h00};
            default:              n_op = '{pwr: 1'b0, rs: 1'b0, byte_val: i_req.value};
        endcase
    end

    // Holding register toward the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_op_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op <= n_op;
        end
    end

    assign o_op       = r_op;
    assign o_op_valid = r_valid;

endmodule

`default_nettype wire

@@ src/clcd_queue.sv @@
// Short op queue between the front and back ends.
`default_nettype none

module clcd_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push_valid,
    output logic               o_push_ready,
    input  wire clcd_pkg::t_op i_push_op,
    output logic               o_pop_valid,
    input  wire logic          i_pop,
    output clcd_pkg::t_op      o_pop_op
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    clcd_pkg::t_op    r_mem [DEPTH];
    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] r_tail;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = i_pop && o_pop_valid;
    assign o_pop_op     = r_mem[r_head];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_tail <= (r_tail == PTR_W'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
            end
            if (w_pop) begin
                r_head <= (r_head == PTR_W'(DEPTH - 1)) ? '0 : r_head + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_tail] <= i_push_op;
        end
    end

`ifndef SYNTHESIS
    // Fill count never passes the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count above depth");
`endif

endmodule

`default_nettype wire

@@ src/clcd_back.sv @@
// Back end: expands each op into timed pin states, one beat per cycle while the pins are not stalled.
`default_nettype none

module clcd_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_op_valid,
    input  wire clcd_pkg::t_op i_op,
    output logic               o_op_pop,
    clcd_pin_if.source         o_pin
);

    clcd_pkg::t_back_state r_state;
    clcd_pkg::t_back_state n_state;
    logic [3:0]            r_nib;
    logic [3:0]            n_nib;
    logic [1:0]            r_phase;
    logic [1:0]            n_phase;

    // Kept pin levels
    logic                  r_rs_pin;
    logic [3:0]            r_data_pins;

    // Output register
    logic                  r_out_valid;
    logic                  r_o_rs;
    logic                  r_o_e;
    logic [3:0]            r_o_nib;
    logic [5:0]            r_o_hold;
    logic                  r_o_last;

    logic                  w_emit;
    logic                  w_final;
    clcd_pkg::t_pwr_nib    w_ent;
    logic [2:0]            w_extra;
    logic                  st_rs;
    logic                  st_e;
    logic [3:0]            st_nib;
    logic [5:0]            st_hold;
    logic                  st_last;

    assign w_emit = i_op_valid && (!r_out_valid || o_pin.ready);
    assign w_ent  = clcd_pkg::pwr_nibble(r_nib);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= clcd_pkg::ST_HEAD;
            r_nib   <= '0;
            r_phase <= clcd_pkg::PH_SETUP;
        end else begin
            r_state <= n_state;
            r_nib   <= n_nib;
            r_phase <= n_phase;
        end
    end

    // Next state and the pin state of this cycle
    always_comb begin
        n_state = r_state;
        n_nib   = r_nib;
        n_phase = r_phase;
        w_final = i_op.pwr ? (r_nib == clcd_pkg::PWR_LAST_NIB)
                           : (r_nib == clcd_pkg::BYTE_LAST_NIB);
        w_extra = i_op.pwr ? w_ent.extra : 3'd0;
        st_rs   = i_op.rs;
        st_e    = 1'b0;
        st_nib  = i_op.byte_val[7:4];
        st_hold = clcd_pkg::HOLD_PULSE;
        st_last = 1'b0;
        case (r_state)
            clcd_pkg::ST_HEAD: begin
                if (i_op.pwr) begin
                    // Initial wait shows the kept levels
                    st_rs   = r_rs_pin;
                    st_nib  = r_data_pins;
                    st_hold = clcd_pkg::HOLD_WAIT;
                    if (w_emit) begin
                        n_state = clcd_pkg::ST_NIBBLE;
                        n_nib   = '0;
                        n_phase = clcd_pkg::PH_SETUP;
                    end
                end else begin
                    // High nibble setup phase
                    st_rs  = i_op.rs;
                    st_nib = i_op.byte_val[7:4];
                    if (w_emit) begin
                        n_state = clcd_pkg::ST_NIBBLE;
                        n_nib   = '0;
                        n_phase = clcd_pkg::PH_HIGH;
                    end
                end
            end
            clcd_pkg::ST_NIBBLE: begin
                if (i_op.pwr) begin
                    st_rs  = w_ent.keep_rs ? r_rs_pin : 1'b0;
                    st_nib = w_ent.nibble;
                end else begin
                    st_rs  = i_op.rs;
                    st_nib = r_nib[0] ? i_op.byte_val[3:0] : i_op.byte_val[7:4];
                end
                st_e    = (r_phase == clcd_pkg::PH_HIGH);
                st_hold = (r_phase == clcd_pkg::PH_SETTLE)
                        ? clcd_pkg::HOLD_SETTLE + {3'b000, w_extra}
                        : clcd_pkg::HOLD_PULSE;
                st_last = (r_phase == clcd_pkg::PH_SETTLE) && w_final;
                if (w_emit) begin
                    if (r_phase == clcd_pkg::PH_SETTLE) begin
                        n_phase = clcd_pkg::PH_SETUP;
                        if (w_final) begin
                            n_state = clcd_pkg::ST_HEAD;
                            n_nib   = '0;
                        end else begin
                            n_nib = r_nib + 1'b1;
                        end
                    end else begin
                        n_phase = r_phase + 1'b1;
                    end
                end
            end
            default: begin
                n_state = clcd_pkg::ST_HEAD;
                n_nib   = '0;
                n_phase = clcd_pkg::PH_SETUP;
            end
        endcase
    end

    assign o_op_pop = w_emit && st_last;

    // Kept pin levels follow every emitted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rs_pin    <= 1'b0;
            r_data_pins <= 4'h0;
        end else if (w_emit) begin
            r_rs_pin    <= st_rs;
            r_data_pins <= st_nib;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_pin.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_o_rs   <= st_rs;
            r_o_e    <= st_e;
            r_o_nib  <= st_nib;
            r_o_hold <= st_hold;
            r_o_last <= st_last;
        end
    end

    assign o_pin.valid        = r_out_valid;
    assign o_pin.rs_level     = r_o_rs;
    assign o_pin.enable_level = r_o_e;
    assign o_pin.nibble       = r_o_nib;
    assign o_pin.hold_ms      = r_o_hold;
    assign o_pin.last         = r_o_last;

`ifndef SYNTHESIS
    // A run starts with cleared counters
    a_head_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == clcd_pkg::ST_HEAD) |-> (r_nib == '0 && r_phase == clcd_pkg::PH_SETUP))
        else $error("sequencer counters not cleared at run start");

    // The strobe is high only for a 1 ms beat
    a_strobe_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_e) |-> (r_o_hold == clcd_pkg::HOLD_PULSE && !r_o_last))
        else $error("strobe beat with wrong hold or marked last");

    // The head op leaves the queue only on a final settle beat
    a_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_op_pop |=> (r_out_valid && r_o_last && !r_o_e))
        else $error("op popped without a final beat");
`endif

endmodule

`default_nettype wire
